@@ rtl/core/bsl_pkg.sv @@
package bsl_pkg;

  // List geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned POS_W  = 5;
  localparam int unsigned CAP_W  = 5;
  // Common width for comparing positions, counts and capacities
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Command codes
  localparam logic [2:0] CMD_INSERT_AT    = 3'd0;
  localparam logic [2:0] CMD_ADD_FIRST    = 3'd1;
  localparam logic [2:0] CMD_ADD_LAST     = 3'd2;
  localparam logic [2:0] CMD_REMOVE_FIRST = 3'd3;
  localparam logic [2:0] CMD_REMOVE_LAST  = 3'd4;
  localparam logic [2:0] CMD_SEARCH       = 3'd5;
  localparam logic [2:0] CMD_READ_LAST    = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_POS  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // What a cell does with its entry at each clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

endpackage

@@ rtl/core/bsl_cell.sv @@
module bsl_cell (
  input  logic                         clk,
  input  bsl_pkg::cell_ctl_t           ctl,
  input  logic [bsl_pkg::DATA_W-1:0]   left_entry,
  input  logic [bsl_pkg::DATA_W-1:0]   right_entry,
  input  logic [bsl_pkg::DATA_W-1:0]   operand,
  output logic [bsl_pkg::DATA_W-1:0]   entry,
  output logic                         match
);

  logic [bsl_pkg::DATA_W-1:0] entry_next;

  // Pick the next entry: hold, load the operand, or take a neighbor's entry
  always_comb begin
    unique case (ctl.op)
      bsl_pkg::CELL_HOLD:       entry_next = entry;
      bsl_pkg::CELL_LOAD:       entry_next = operand;
      bsl_pkg::CELL_FROM_LEFT:  entry_next = left_entry;
      bsl_pkg::CELL_FROM_RIGHT: entry_next = right_entry;
      default:                  entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // Compare the stored entry against the search value
  assign match = (entry == operand);

endmodule

@@ rtl/core/bounded_shift_list_engine_top.sv @@
// Result: a command's result is registered and shows in the cycle after its transfer.
// Throughput: one command per cycle; every cell shifts, loads or compares at once,
// and the single output register stalls input only while its result is not taken.
// Reset (synchronous, active high): count cleared, capacity set to 16, output empty.
// List entries are not reset; only entries below the count are ever read.
module bounded_shift_list_engine_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [bsl_pkg::CAP_W-1:0]     cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    command,
  input  logic [bsl_pkg::POS_W-1:0]     position,
  input  logic signed [31:0]            operand_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic                          found,
  output logic signed [31:0]            last_value,
  output logic [4:0]                    entry_count,
  output logic                          is_empty,
  output logic                          is_full
);

  localparam int unsigned DEPTH  = bsl_pkg::DEPTH;
  localparam int unsigned DATA_W = bsl_pkg::DATA_W;
  localparam int unsigned CMP_W  = bsl_pkg::CMP_W;
  localparam int unsigned CNT_W  = bsl_pkg::CNT_W;
  localparam int unsigned IDX_W  = bsl_pkg::IDX_W;

  logic [bsl_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;

  logic [DATA_W-1:0]         cell_entry [DEPTH];
  logic [DEPTH-1:0]          cell_match;
  bsl_pkg::cell_ctl_t        cell_ctl   [DEPTH];

  logic                      xfer_in;
  logic [CMP_W-1:0]          count_c;
  logic [CMP_W-1:0]          cap_eff;
  logic [CMP_W-1:0]          ins_pos;
  logic                      is_insert;
  logic                      ins_ok;
  logic                      rem_first_ok;
  logic [1:0]                status_next;
  logic                      found_next;
  logic [DATA_W-1:0]         last_next;

  // Accept while the output register is free or being drained
  assign in_stall = out_valid & out_stall;
  assign xfer_in  = in_valid & ~in_stall;

  assign count_c = CMP_W'(count);
  assign cap_eff = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);

  // Decode the insert target
  always_comb begin
    is_insert = 1'b0;
    ins_pos   = '0;
    unique case (command)
      bsl_pkg::CMD_INSERT_AT: begin
        is_insert = 1'b1;
        ins_pos   = CMP_W'(position);
      end
      bsl_pkg::CMD_ADD_FIRST: begin
        is_insert = 1'b1;
        ins_pos   = '0;
      end
      bsl_pkg::CMD_ADD_LAST: begin
        is_insert = 1'b1;
        ins_pos   = count_c;
      end
      default: begin
        is_insert = 1'b0;
        ins_pos   = '0;
      end
    endcase
  end

  // Work out status, search result, read value and new count
  always_comb begin
    status_next  = bsl_pkg::ST_OK;
    found_next   = 1'b0;
    last_next    = '0;
    count_next   = count;
    ins_ok       = 1'b0;
    rem_first_ok = 1'b0;
    if (is_insert) begin
      priority if (ins_pos > count_c) begin
        status_next = bsl_pkg::ST_BAD_POS;
      end else if (count_c >= cap_eff) begin
        status_next = bsl_pkg::ST_FULL;
      end else begin
        ins_ok     = 1'b1;
        count_next = count + CNT_W'(1);
      end
    end else begin
      unique case (command)
        bsl_pkg::CMD_REMOVE_FIRST: begin
          if (count == '0) begin
            status_next = bsl_pkg::ST_EMPTY;
          end else begin
            rem_first_ok = 1'b1;
            count_next   = count - CNT_W'(1);
          end
        end
        bsl_pkg::CMD_REMOVE_LAST: begin
          if (count == '0) begin
            status_next = bsl_pkg::ST_EMPTY;
          end else begin
            count_next = count - CNT_W'(1);
          end
        end
        bsl_pkg::CMD_SEARCH: begin
          for (int i = 0; i < DEPTH; i++) begin
            if (cell_match[i] && (CMP_W'(i) < count_c)) begin
              found_next = 1'b1;
            end
          end
        end
        bsl_pkg::CMD_READ_LAST: begin
          if (count == '0) begin
            status_next = bsl_pkg::ST_EMPTY;
          end else begin
            last_next = cell_entry[IDX_W'(count - CNT_W'(1))];
          end
        end
        default: begin
          status_next = bsl_pkg::ST_OK;
        end
      endcase
    end
  end

  // Steer each cell: open a gap at the insert point or close the head
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].op = bsl_pkg::CELL_HOLD;
      if (xfer_in && ins_ok) begin
        priority if (CMP_W'(i) == ins_pos) begin
          cell_ctl[i].op = bsl_pkg::CELL_LOAD;
        end else if (CMP_W'(i) > ins_pos) begin
          cell_ctl[i].op = bsl_pkg::CELL_FROM_LEFT;
        end else begin
          cell_ctl[i].op = bsl_pkg::CELL_HOLD;
        end
      end else if (xfer_in && rem_first_ok) begin
        cell_ctl[i].op = bsl_pkg::CELL_FROM_RIGHT;
      end
    end
  end

  // Row of cells, each linked to its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (g == 0) begin : g_head
      assign left_in = operand_value;
    end else begin : g_mid_l
      assign left_in = cell_entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_in = cell_entry[g];
    end else begin : g_mid_r
      assign right_in = cell_entry[g+1];
    end
    bsl_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[g]),
      .left_entry  (left_in),
      .right_entry (right_in),
      .operand     (operand_value),
      .entry       (cell_entry[g]),
      .match       (cell_match[g])
    );
  end

  // Hold capacity, count and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= bsl_pkg::CAP_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (xfer_in) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer_in) begin
      status      <= status_next;
      found       <= found_next;
      last_value  <= signed'(last_next);
      entry_count <= 5'(count_next);
      is_empty    <= (count_next == '0);
      is_full     <= (CMP_W'(count_next) >= cap_eff);
    end
  end

endmodule
